>>> hw/rtl/point_in_polygon_filter_assert.svh
// Assertion macros for the point-in-polygon filter.
`ifndef POINT_IN_POLYGON_FILTER_ASSERT_SVH
`define POINT_IN_POLYGON_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
`define PIP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PIP_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PIP_ASSERT(label, clk, rst_n, prop, msg)
`define PIP_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

>>> hw/rtl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants of the point-in-polygon filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package pip_pkg;
    localparam int MaxVertices = 16;
    localparam int IdxW = $clog2(MaxVertices);
    localparam int SizeW = 5;
    localparam int CoordW = 32;
    localparam int QDepth = 2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEST = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EDGE,
        ST_MUL,
        ST_DONE
    } eng_state_t;

    // One test point waiting in the queue.
    typedef struct packed {
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic signed [CoordW-1:0] z;
    } point_t;

    typedef struct packed {
        logic valid;
        logic stall;
    } hs_t;
endpackage

>>> hw/rtl/pip_front.sv
// ----------------------------------------------------------------------------
// pip_front
// Accepts transactions, writes vertex loads, queues test points.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "point_in_polygon_filter_assert.svh"
module pip_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               valid,
    output logic                               stall,
    input  logic                               cmd,
    input  logic [pip_pkg::IdxW-1:0]           vertex_index,
    input  logic signed [pip_pkg::CoordW-1:0]  coord_x,
    input  logic signed [pip_pkg::CoordW-1:0]  coord_y,
    input  logic signed [pip_pkg::CoordW-1:0]  coord_z,
    output logic                               vwr_en,
    output logic [pip_pkg::IdxW-1:0]           vwr_idx,
    output logic signed [pip_pkg::CoordW-1:0]  vwr_x,
    output logic signed [pip_pkg::CoordW-1:0]  vwr_y,
    output pip_pkg::point_t                    q_pt,
    output pip_pkg::hs_t                       q_hs_o,
    input  logic                               q_pop
);
    import pip_pkg::*;

    point_t q_mem_reg [QDepth];
    logic q_wp_reg, q_rp_reg;
    logic [1:0] q_cnt_reg;
    logic acc, push, busy;

    // Loads wait while tests are queued so that a test sees earlier loads only.
    assign busy   = (q_cnt_reg != 2'd0);
    assign stall  = (cmd == CMD_LOAD) ? busy : (q_cnt_reg == 2'(QDepth));
    assign acc    = valid && !stall;
    assign push   = acc && (cmd == CMD_TEST);
    assign vwr_en = acc && (cmd == CMD_LOAD);
    assign vwr_idx = vertex_index;
    assign vwr_x = coord_x;
    assign vwr_y = coord_y;
    assign q_pt = q_mem_reg[q_rp_reg];
    assign q_hs_o.valid = busy;
    assign q_hs_o.stall = stall;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[q_wp_reg] <= '{x: coord_x, y: coord_y, z: coord_z};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wp_reg <= 1'b0;
            q_rp_reg <= 1'b0;
            q_cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                q_wp_reg <= ~q_wp_reg;
            end
            if (q_pop)
            begin
                q_rp_reg <= ~q_rp_reg;
            end
            q_cnt_reg <= q_cnt_reg + 2'(push) - 2'(q_pop);
        end
    end

    `PIP_ASSERT_NEVER(a_no_pop_empty, clk, rst_n, q_pop && q_cnt_reg == 2'd0, "pop of empty queue")
    `PIP_ASSERT_NEVER(a_no_overflow, clk, rst_n, q_cnt_reg > 2'(QDepth), "queue overflow")
    `PIP_ASSERT(a_load_only_empty, clk, rst_n, vwr_en |-> q_cnt_reg == 2'd0, "load while queued")
endmodule

>>> hw/rtl/pip_engine.sv
// ----------------------------------------------------------------------------
// pip_engine
// Walks the polygon edges one at a time and drives the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "point_in_polygon_filter_assert.svh"
module pip_engine (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [pip_pkg::SizeW-1:0]          polygon_size,
    input  logic                               vwr_en,
    input  logic [pip_pkg::IdxW-1:0]           vwr_idx,
    input  logic signed [pip_pkg::CoordW-1:0]  vwr_x,
    input  logic signed [pip_pkg::CoordW-1:0]  vwr_y,
    input  pip_pkg::point_t                    q_pt,
    input  logic                               q_valid,
    output logic                               q_pop,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               inside_res,
    output logic signed [pip_pkg::CoordW-1:0]  out_x,
    output logic signed [pip_pkg::CoordW-1:0]  out_y,
    output logic signed [pip_pkg::CoordW-1:0]  out_z
);
    import pip_pkg::*;

    localparam int DW = CoordW + 1;
    localparam int PW = 2 * DW;

    logic signed [CoordW-1:0] vx_mem [MaxVertices];
    logic signed [CoordW-1:0] vy_mem [MaxVertices];

    eng_state_t state_reg, state_next;
    logic [IdxW:0] i_reg, i_next;
    logic [IdxW-1:0] j_reg, j_next;
    logic [IdxW:0] n_eff;
    logic c_reg, c_next;
    logic signed [CoordW-1:0] xi_reg, yi_reg, xj_reg, yj_reg;
    logic signed [PW-1:0] pl_reg, pr_reg;
    logic signed [DW-1:0] dy_reg;
    logic strad_reg;
    logic pend_reg;
    logic ov_reg, res_reg;
    point_t opt_reg;
    logic out_free, ld_edge, ld_mul, finish;
    logic signed [DW-1:0] dx_t, dy, dxe, dyt;
    logic strad, hit;

    assign n_eff = (polygon_size > SizeW'(MaxVertices)) ? (IdxW+1)'(MaxVertices)
                                                          : polygon_size[IdxW:0];
    assign out_free = !ov_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (vwr_en)
        begin
            vx_mem[vwr_idx] <= vwr_x;
            vy_mem[vwr_idx] <= vwr_y;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = (n_eff < (IdxW+1)'(3)) ? ST_DONE : ST_EDGE;
                end
            end
            ST_EDGE: state_next = ST_MUL;
            ST_MUL:  state_next = (i_reg == n_eff) ? ST_DONE : ST_EDGE;
            ST_DONE: state_next = out_free ? ST_IDLE : ST_DONE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ld_edge = (state_reg == ST_EDGE);
        ld_mul  = (state_reg == ST_MUL);
        finish  = (state_reg == ST_DONE) && out_free;
        q_pop   = finish;
    end

    assign dx_t = DW'(q_pt.x) - DW'(xi_reg);
    assign dy   = DW'(yj_reg) - DW'(yi_reg);
    assign dxe  = DW'(xj_reg) - DW'(xi_reg);
    assign dyt  = DW'(q_pt.y) - DW'(yi_reg);
    assign strad = (yi_reg > q_pt.y) != (yj_reg > q_pt.y);
    assign hit = (dy_reg > 0) ? (pl_reg < pr_reg) : (pr_reg < pl_reg);

    always_comb
    begin
        i_next = i_reg;
        j_next = j_reg;
        c_next = c_reg;
        if (state_reg == ST_IDLE)
        begin
            i_next = '0;
            j_next = IdxW'(n_eff - (IdxW+1)'(1));
            c_next = 1'b0;
        end
        else
        begin
            if (ld_edge)
            begin
                j_next = i_reg[IdxW-1:0];
                i_next = i_reg + (IdxW+1)'(1);
            end
            // The products of an edge are compared in the cycle after they are formed.
            if (pend_reg && strad_reg && hit)
            begin
                c_next = !c_reg;
            end
        end
    end

    // Stage one reads the edge ends; stage two forms the two exact products.
    always_ff @(posedge clk)
    begin
        if (ld_edge)
        begin
            xi_reg <= vx_mem[i_reg[IdxW-1:0]];
            yi_reg <= vy_mem[i_reg[IdxW-1:0]];
            xj_reg <= vx_mem[j_reg];
            yj_reg <= vy_mem[j_reg];
        end
        if (ld_mul)
        begin
            pl_reg <= PW'(dx_t) * PW'(dy);
            pr_reg <= PW'(dxe) * PW'(dyt);
            dy_reg <= dy;
            strad_reg <= strad;
        end
        if (finish)
        begin
            opt_reg <= q_pt;
            res_reg <= c_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg <= '0;
            j_reg <= '0;
            c_reg <= 1'b0;
            pend_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg <= i_next;
            j_reg <= j_next;
            c_reg <= c_next;
            pend_reg <= ld_mul;
            if (finish)
            begin
                ov_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    assign out_valid = ov_reg;
    assign inside_res = res_reg;
    assign out_x = opt_reg.x;
    assign out_y = opt_reg.y;
    assign out_z = opt_reg.z;

    `PIP_ASSERT(a_pop_done, clk, rst_n, q_pop |-> state_reg == ST_DONE, "pop outside done")
    `PIP_ASSERT(a_res_after_pop, clk, rst_n, q_pop |=> out_valid, "result lost")
    `PIP_ASSERT(a_idx_range, clk, rst_n, ld_edge |-> i_reg < n_eff, "edge index range")
endmodule

>>> hw/rtl/point_in_polygon_filter.sv
// A polygon under three vertices skips the edge walk; a larger one is walked
// edge by edge, each edge through the vertex read and then the multiply step.
// Test points are processed one at a time by the single shared edge datapath
// (vertex read, then two 33x33 products); the two-entry queue holds the point
// under test and one more.
// Reset: rst_n clears the queue, the engine and polygon_size; vertex slots
// keep no reset value and must be loaded before use.
// ----------------------------------------------------------------------------
// point_in_polygon_filter
// Crossing-number point-in-polygon test over a loaded vertex list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module point_in_polygon_filter (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [pip_pkg::SizeW-1:0]          cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               cmd,
    input  logic [pip_pkg::IdxW-1:0]           vertex_index,
    input  logic signed [pip_pkg::CoordW-1:0]  coord_x,
    input  logic signed [pip_pkg::CoordW-1:0]  coord_y,
    input  logic signed [pip_pkg::CoordW-1:0]  coord_z,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               inside_res,
    output logic signed [pip_pkg::CoordW-1:0]  out_x,
    output logic signed [pip_pkg::CoordW-1:0]  out_y,
    output logic signed [pip_pkg::CoordW-1:0]  out_z
);
    import pip_pkg::*;

    logic [SizeW-1:0] size_reg;
    logic vwr_en, q_pop;
    logic [IdxW-1:0] vwr_idx;
    logic signed [CoordW-1:0] vwr_x, vwr_y;
    point_t q_pt;
    hs_t q_hs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= '0;
        end
        else if (cfg_we)
        begin
            size_reg <= cfg_wdata;
        end
    end

    pip_front u_front (
        .clk, .rst_n, .valid(in_valid), .stall(in_stall), .cmd, .vertex_index,
        .coord_x, .coord_y, .coord_z, .vwr_en, .vwr_idx, .vwr_x, .vwr_y,
        .q_pt, .q_hs_o(q_hs), .q_pop
    );

    pip_engine u_engine (
        .clk, .rst_n, .polygon_size(size_reg), .vwr_en, .vwr_idx, .vwr_x, .vwr_y,
        .q_pt, .q_valid(q_hs.valid), .q_pop, .out_valid, .out_stall, .inside_res,
        .out_x, .out_y, .out_z
    );
endmodule
